// ===== rtl/core/ksd_pkg.sv =====
// Shared types, constants and the Dayhoff PAM table for the sequence distance block.
// No dependencies; every other file in rtl/core imports this package.
package ksd_pkg;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] MAX_SITES = 17'd65536;

  localparam logic [4:0] NUC_LIMIT  = 5'd4;
  localparam logic [4:0] PROT_LIMIT = 5'd20;

  localparam logic [15:0] DIST_MAX = 16'd40960;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;

  localparam int PAM_LAST = 180;

  // Reciprocal of 100 for dividends below 2^22: ceil(2^29 / 100), product taken >> 29.
  localparam logic [22:0] PAM_RECIP = 23'd5368710;

  // Configuration register indexes.
  localparam logic CFG_NUC_MODE = 1'b0;
  localparam logic CFG_KIMURA   = 1'b1;

  // One finished pair, handed from the front part to the back part.
  typedef struct packed {
    logic [CNT_W-1:0] mism;
    logic [CNT_W-1:0] sites;
    logic             corr;
  } pair_t;

  // One result beat.
  typedef struct packed {
    logic [15:0]      distance;
    logic             defined;
    logic [CNT_W-1:0] mism;
    logic [CNT_W-1:0] sites;
  } result_t;

  localparam logic [9:0] PAM_TABLE [0:PAM_LAST] = '{
    10'd195, 10'd196, 10'd197, 10'd198, 10'd199, 10'd200, 10'd200, 10'd201, 10'd202, 10'd203,
    10'd204, 10'd205, 10'd206, 10'd207, 10'd208, 10'd209, 10'd209, 10'd210, 10'd211, 10'd212,
    10'd213, 10'd214, 10'd215, 10'd216, 10'd217, 10'd218, 10'd219, 10'd220, 10'd221, 10'd222,
    10'd223, 10'd224, 10'd226, 10'd227, 10'd228, 10'd229, 10'd230, 10'd231, 10'd232, 10'd233,
    10'd234, 10'd236, 10'd237, 10'd238, 10'd239, 10'd240, 10'd241, 10'd243, 10'd244, 10'd245,
    10'd246, 10'd248, 10'd249, 10'd250, 10'd252, 10'd253, 10'd254, 10'd255, 10'd257, 10'd258,
    10'd260, 10'd261, 10'd262, 10'd264, 10'd265, 10'd267, 10'd268, 10'd270, 10'd271, 10'd273,
    10'd274, 10'd276, 10'd277, 10'd279, 10'd281, 10'd282, 10'd284, 10'd285, 10'd287, 10'd289,
    10'd291, 10'd292, 10'd294, 10'd296, 10'd298, 10'd299, 10'd301, 10'd303, 10'd305, 10'd307,
    10'd309, 10'd311, 10'd313, 10'd315, 10'd317, 10'd319, 10'd321, 10'd323, 10'd325, 10'd328,
    10'd330, 10'd332, 10'd335, 10'd337, 10'd339, 10'd342, 10'd344, 10'd347, 10'd349, 10'd352,
    10'd354, 10'd357, 10'd360, 10'd362, 10'd365, 10'd368, 10'd371, 10'd374, 10'd377, 10'd380,
    10'd383, 10'd386, 10'd389, 10'd393, 10'd396, 10'd399, 10'd403, 10'd407, 10'd410, 10'd414,
    10'd418, 10'd422, 10'd426, 10'd430, 10'd434, 10'd438, 10'd442, 10'd447, 10'd451, 10'd456,
    10'd461, 10'd466, 10'd471, 10'd476, 10'd482, 10'd487, 10'd493, 10'd498, 10'd504, 10'd511,
    10'd517, 10'd524, 10'd531, 10'd538, 10'd545, 10'd553, 10'd560, 10'd569, 10'd577, 10'd586,
    10'd595, 10'd605, 10'd615, 10'd626, 10'd637, 10'd649, 10'd661, 10'd675, 10'd688, 10'd703,
    10'd719, 10'd736, 10'd754, 10'd775, 10'd796, 10'd819, 10'd845, 10'd874, 10'd907, 10'd945,
    10'd988
  };

endpackage

// ===== rtl/core/ksd_front.sv =====
// Front part: takes site beats, classifies each site and keeps the saturating counts.
// Depends on ksd_pkg; hands finished pairs to ksd_fifo.
module ksd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [4:0]    residue_a,
  input  logic [4:0]    residue_b,
  input  logic          last_site,
  input  logic          nuc_mode,
  input  logic          kimura_en,
  input  logic          q_full,
  output logic          q_push,
  output ksd_pkg::pair_t q_data
);
  import ksd_pkg::*;

  logic [CNT_W-1:0] sites_r, mism_r, sites_nxt, mism_nxt, sites_upd, mism_upd;
  logic [4:0]       limit;
  logic             take, valid_site;

  assign full  = q_full;
  assign take  = push && !q_full;
  assign limit = nuc_mode ? NUC_LIMIT : PROT_LIMIT;
  assign valid_site = (residue_a < limit) && (residue_b < limit);

  always_comb begin
    sites_upd = sites_r;
    mism_upd  = mism_r;
    if (valid_site) begin
      if (sites_r < MAX_SITES) sites_upd = sites_r + 1'b1;
      if ((residue_a != residue_b) && (mism_r < MAX_SITES)) mism_upd = mism_r + 1'b1;
    end
    sites_nxt = sites_r;
    mism_nxt  = mism_r;
    if (take) begin
      sites_nxt = last_site ? '0 : sites_upd;
      mism_nxt  = last_site ? '0 : mism_upd;
    end
  end

  assign q_push       = take && last_site;
  assign q_data.mism  = mism_upd;
  assign q_data.sites = sites_upd;
  assign q_data.corr  = kimura_en && !nuc_mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sites_r <= '0;
      mism_r  <= '0;
    end else begin
      sites_r <= sites_nxt;
      mism_r  <= mism_nxt;
    end
  end

endmodule

// ===== rtl/core/ksd_fifo.sv =====
// Two-entry queue of finished pairs between the front and the back part.
// Depends on ksd_pkg for the pair type.
module ksd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ksd_pkg::pair_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ksd_pkg::pair_t rdata
);
  import ksd_pkg::*;

  pair_t      mem_r [0:1];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/ksd_back.sv =====
// Back part: sequencer with a shared long divider, log2 unit and split multiplier.
// Depends on ksd_pkg; drains ksd_fifo and holds the result register.
module ksd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ksd_pkg::pair_t  q_data,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output ksd_pkg::result_t out_data
);
  import ksd_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SETUP  = 13'b0000000000010,
    S_DIV    = 13'b0000000000100,
    S_DIVEND = 13'b0000000001000,
    S_MUL    = 13'b0000000010000,
    S_NUM    = 13'b0000000100000,
    S_NORM   = 13'b0000001000000,
    S_SQ     = 13'b0000010000000,
    S_LOGEND = 13'b0000100000000,
    S_LN1    = 13'b0001000000000,
    S_LN2    = 13'b0010000000000,
    S_LN3    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_RAW = 2'b01,
    PH_PAM = 2'b10
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  pair_t       pair_r, pair_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [29:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [17:0] dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [33:0] nn_r, nn_nxt;
  logic [35:0] ms_r, ms_nxt;
  logic [34:0] num_r, num_nxt, v_r, v_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [30:0] y_r, y_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic [29:0] lden_r, lden_nxt, diff_r, diff_nxt;
  logic        second_r, second_nxt;
  logic [44:0] plo_r, plo_nxt, phi_r, phi_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        def_r, def_nxt;
  result_t     res_r, res_nxt;
  logic        ovld_r, ovld_nxt;

  logic [18:0] rem_sh;
  logic [61:0] sq;
  logic [31:0] sq_t;
  logic [29:0] lcur;
  logic [60:0] acc;
  logic [18:0] four_m, three_n;
  logic [26:0] m_k, n_k;
  logic [27:0] m_2000, n_1499;
  logic [18:0] five_n_m;
  logic [34:0] den;
  logic [7:0]  idx;
  logic [9:0]  entry;
  logic [21:0] pam_x;
  logic [44:0] pam_p;

  assign rem_sh  = {rem_r, dvd_r[29]};
  assign sq      = y_r * y_r;
  assign sq_t    = sq[61:30];
  assign lcur    = {k_r[5:0], frac_r};
  assign acc     = {16'd0, plo_r} + {1'b0, phi_r, 15'd0} + (61'd1 << 41);
  assign four_m  = {pair_r.mism, 2'b00};
  assign three_n = {pair_r.sites, 1'b0} + {2'b00, pair_r.sites};
  assign m_k     = pair_r.mism * 10'd1000;
  assign n_k     = pair_r.sites * 10'd930;
  assign m_2000  = pair_r.mism * 11'd2000;
  assign n_1499  = pair_r.sites * 11'd1499;
  assign five_n_m = {pair_r.sites, 2'b00} + {2'b00, pair_r.sites} + {2'b00, pair_r.mism};
  assign den     = {nn_r[32:0], 2'b00} + {1'b0, nn_r};
  assign idx     = (quo_r > 30'(PAM_LAST)) ? 8'(PAM_LAST) : quo_r[7:0];
  assign entry   = PAM_TABLE[idx];

  // Table entry over 100 in Q4.12, rounded: (entry * 4096 + 50) / 100 by reciprocal.
  assign pam_x   = {entry, 12'd0} + 22'd50;
  assign pam_p   = 45'(pam_x) * 45'(PAM_RECIP);

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !ovld_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    pair_nxt   = pair_r;
    cnt_nxt    = cnt_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    rem_nxt    = rem_r;
    nn_nxt     = nn_r;
    ms_nxt     = ms_r;
    num_nxt    = num_r;
    v_nxt      = v_r;
    k_nxt      = k_r;
    y_nxt      = y_r;
    frac_nxt   = frac_r;
    lden_nxt   = lden_r;
    diff_nxt   = diff_r;
    second_nxt = second_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    dist_nxt   = dist_r;
    def_nxt    = def_r;
    res_nxt    = res_r;
    ovld_nxt   = ovld_r && !out_pop;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pair_nxt  = q_data;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        def_nxt = 1'b1;
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = 6'd30;
        dvs_nxt = {pair_r.sites, 1'b0};
        if (pair_r.sites == '0) begin
          def_nxt   = 1'b0;
          dist_nxt  = '0;
          state_nxt = S_OUT;
        end else if (!pair_r.corr) begin
          dvd_nxt   = {pair_r.mism, 13'd0} + {13'd0, pair_r.sites};
          phase_nxt = PH_RAW;
          state_nxt = S_DIV;
        end else if (four_m < three_n) begin
          state_nxt = S_MUL;
        end else if (m_k > n_k) begin
          dist_nxt  = DIST_MAX;
          state_nxt = S_OUT;
        end else begin
          dvd_nxt   = {2'b00, m_2000 - n_1499};
          phase_nxt = PH_PAM;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dvd_nxt = {dvd_r[28:0], 1'b0};
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_nxt = 18'(rem_sh - {1'b0, dvs_r});
          quo_nxt = {quo_r[28:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[17:0];
          quo_nxt = {quo_r[28:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_DIVEND;
      end
      S_DIVEND: begin
        case (phase_r)
          PH_PAM: begin
            dist_nxt  = pam_p[44:29];
            state_nxt = S_OUT;
          end
          default: begin
            dist_nxt  = quo_r[15:0];
            state_nxt = S_OUT;
          end
        endcase
      end
      S_MUL: begin
        nn_nxt    = pair_r.sites * pair_r.sites;
        ms_nxt    = pair_r.mism * five_n_m;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        num_nxt    = den - ms_r[34:0];
        v_nxt      = den;
        k_nxt      = 6'd34;
        second_nxt = 1'b0;
        state_nxt  = S_NORM;
      end
      S_NORM: begin
        if (v_r[34]) begin
          y_nxt     = v_r[34:4];
          frac_nxt  = '0;
          cnt_nxt   = 6'd24;
          state_nxt = S_SQ;
        end else begin
          v_nxt = {v_r[33:0], 1'b0};
          k_nxt = k_r - 6'd1;
        end
      end
      S_SQ: begin
        if (sq_t[31]) begin
          y_nxt    = sq_t[31:1];
          frac_nxt = {frac_r[22:0], 1'b1};
        end else begin
          y_nxt    = sq_t[30:0];
          frac_nxt = {frac_r[22:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_LOGEND;
      end
      S_LOGEND: begin
        if (!second_r) begin
          lden_nxt   = lcur;
          v_nxt      = num_r;
          k_nxt      = 6'd34;
          second_nxt = 1'b1;
          state_nxt  = S_NORM;
        end else begin
          diff_nxt  = (lden_r > lcur) ? lden_r - lcur : '0;
          state_nxt = S_LN1;
        end
      end
      S_LN1: begin
        plo_nxt   = diff_r[14:0] * LN2_Q30;
        state_nxt = S_LN2;
      end
      S_LN2: begin
        phi_nxt   = diff_r[29:15] * LN2_Q30;
        state_nxt = S_LN3;
      end
      S_LN3: begin
        dist_nxt  = acc[57:42];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovld_r || out_pop) begin
          res_nxt.distance = dist_r;
          res_nxt.defined  = def_r;
          res_nxt.mism     = pair_r.mism;
          res_nxt.sites    = pair_r.sites;
          ovld_nxt         = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_RAW;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r   <= pair_nxt;
    cnt_r    <= cnt_nxt;
    dvd_r    <= dvd_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    rem_r    <= rem_nxt;
    nn_r     <= nn_nxt;
    ms_r     <= ms_nxt;
    num_r    <= num_nxt;
    v_r      <= v_nxt;
    k_r      <= k_nxt;
    y_r      <= y_nxt;
    frac_r   <= frac_nxt;
    lden_r   <= lden_nxt;
    diff_r   <= diff_nxt;
    second_r <= second_nxt;
    plo_r    <= plo_nxt;
    phi_r    <= phi_nxt;
    dist_r   <= dist_nxt;
    def_r    <= def_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== rtl/core/kimura_sequence_distance.sv =====
// Top level of the pairwise sequence distance block: configuration registers and wiring.
// Depends on ksd_pkg, ksd_front, ksd_fifo and ksd_back.
//
//   Channel   Ports                                           Beat taken when
//   input     in_push, in_full, in_residue_a/b, in_last_site  in_push && !in_full
//   result    out_empty, out_pop, out_distance, out_defined,  out_pop && !out_empty
//             out_mismatches, out_sites_compared
//   config    cfg_we, cfg_index, cfg_wdata                    cfg_we
//
// Site beats are taken one per cycle while in_full is low; the front part
// counts each beat as it is taken. Each last-site beat places the pair
// into a two-entry queue; in_full rises only while that queue is full.
// The back part's time per pair is set by the one-bit-a-step divider for an
// uncorrected or Dayhoff table pair and by the one-square-a-cycle log2 unit
// for a logarithm pair.
// Reset is synchronous and active low; it clears the counts, the queue, the
// sequencer and the result valid flag, and sets both modes to zero.
module kimura_sequence_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [4:0]  in_residue_a,
  input  logic [4:0]  in_residue_b,
  input  logic        in_last_site,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_distance,
  output logic        out_defined,
  output logic [16:0] out_mismatches,
  output logic [16:0] out_sites_compared,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);
  import ksd_pkg::*;

  logic    nuc_mode_r, kimura_en_r;
  logic    q_full, q_empty, q_push, q_pop;
  pair_t   q_wdata, q_rdata;
  result_t res;

  // Configuration registers. Writes must arrive only while the block is idle (the
  // block does not enforce it); then the flag captured with each pair is current.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nuc_mode_r  <= 1'b0;
      kimura_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUC_MODE: nuc_mode_r  <= cfg_wdata;
        CFG_KIMURA:   kimura_en_r <= cfg_wdata;
        default:      nuc_mode_r  <= nuc_mode_r;
      endcase
    end
  end

  // Front part: classification and saturating counts.
  ksd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .residue_a (in_residue_a),
    .residue_b (in_residue_b),
    .last_site (in_last_site),
    .nuc_mode  (nuc_mode_r),
    .kimura_en (kimura_en_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Queue of finished pairs, so that sites of the next pair keep flowing
  // while the back part is still busy with the previous one.
  ksd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Back part: distance arithmetic and the result register.
  ksd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (res)
  );

  assign out_distance       = res.distance;
  assign out_defined        = res.defined;
  assign out_mismatches     = res.mism;
  assign out_sites_compared = res.sites;

endmodule
